@@ hw/rtl/spi_tbs_pkg.sv @@
`timescale 1ns / 1ps

package spi_tbs_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SPI_MODE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LENIENT_DESELECT = 1'd1;

  // Select event codes.
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_SELECT   = 2'd1,
    EV_DESELECT = 2'd2
  } select_event_e;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_CLK_AT_SELECT = 3'd1,
    ERR_CLK_AT_DESEL  = 3'd2,
    ERR_PARTIAL_BYTE  = 3'd3,
    ERR_DATA_MOVED    = 3'd4
  } error_code_e;

  // Bits in one byte exchange, and the count at which lenient deselect completes it.
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitCntW = 3;
  localparam logic [BitCntW-1:0] LastBit = 3'd7;

endpackage

@@ hw/rtl/spi_target_byte_shifter.sv @@
// SPI target byte shifter for modes 0 to 3, fed one pin sample per transfer.
// Each input transfer's result is registered and held in the result register until taken.
// Throughput: one sample per cycle while out_ready_i is high; one skid-free result register.
// Reset: rst_ni is asynchronous, active low; it clears the shift state, the mode registers
// and the result valid flag, leaving the block deselected.
`timescale 1ns / 1ps

module spi_target_byte_shifter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [spi_tbs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [spi_tbs_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // Pin sample channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mosi_i,
  input  logic                                sck_i,
  input  logic                                chip_select_n_i,
  input  logic [spi_tbs_pkg::ByteW-1:0]       tx_byte_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                rx_valid_o,
  output logic [spi_tbs_pkg::ByteW-1:0]       rx_byte_o,
  output logic                                tx_taken_o,
  output logic [1:0]                          select_event_o,
  output logic [2:0]                          error_code_o,
  output logic                                miso_o,
  output logic                                miso_drive_o
);

  // Configuration registers.
  logic [1:0] spi_mode_q;
  logic       lenient_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spi_mode_q <= 2'd0;
      lenient_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spi_tbs_pkg::CFG_SPI_MODE:         spi_mode_q <= cfg_wdata_i;
        spi_tbs_pkg::CFG_LENIENT_DESELECT: lenient_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic cpol;
  logic cpha;
  logic sample_level;

  assign cpol         = spi_mode_q[1];
  assign cpha         = spi_mode_q[0];
  assign sample_level = ~(cpol ^ cpha);

  // Protocol state.
  logic                                   selected_q, selected_d;
  logic                                   last_clock_q, last_clock_d;
  logic                                   last_data_q, last_data_d;
  logic                                   skip_edge_q, skip_edge_d;
  logic [spi_tbs_pkg::ByteW-1:0]          in_shift_q, in_shift_d;
  logic [spi_tbs_pkg::ByteW-1:0]          out_shift_q, out_shift_d;
  logic [spi_tbs_pkg::BitCntW-1:0]        bit_count_q, bit_count_d;

  // Result fields for the current sample.
  logic                                   rx_valid_d;
  logic [spi_tbs_pkg::ByteW-1:0]          rx_byte_d;
  logic                                   tx_taken_d;
  spi_tbs_pkg::select_event_e             event_d;
  spi_tbs_pkg::error_code_e               error_d;

  // Handshake: accept whenever the result register is empty or being drained.
  logic out_valid_q;
  logic in_fire;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // Next state and result for one pin sample.
  always_comb begin
    selected_d   = selected_q;
    last_clock_d = last_clock_q;
    last_data_d  = last_data_q;
    skip_edge_d  = skip_edge_q;
    in_shift_d   = in_shift_q;
    out_shift_d  = out_shift_q;
    bit_count_d  = bit_count_q;
    rx_valid_d   = 1'b0;
    rx_byte_d    = '0;
    tx_taken_d   = 1'b0;
    event_d      = spi_tbs_pkg::EV_NONE;
    error_d      = spi_tbs_pkg::ERR_NONE;

    if (!selected_q) begin
      if (!chip_select_n_i) begin
        if (sck_i != cpol) begin
          error_d = spi_tbs_pkg::ERR_CLK_AT_SELECT;
        end
        selected_d   = 1'b1;
        bit_count_d  = '0;
        last_data_d  = mosi_i;
        last_clock_d = sck_i;
        skip_edge_d  = cpha;
        event_d      = spi_tbs_pkg::EV_SELECT;
        out_shift_d  = tx_byte_i;
        tx_taken_d   = 1'b1;
      end
    end else if (chip_select_n_i) begin
      // Deselect, optionally completing a byte whose last shift edge is missing.
      if (lenient_q && (bit_count_q == spi_tbs_pkg::LastBit)) begin
        rx_valid_d  = 1'b1;
        rx_byte_d   = in_shift_q;
        out_shift_d = tx_byte_i;
        tx_taken_d  = 1'b1;
        bit_count_d = '0;
      end else if (sck_i != cpol) begin
        error_d = spi_tbs_pkg::ERR_CLK_AT_DESEL;
      end else if (bit_count_q != '0) begin
        error_d = spi_tbs_pkg::ERR_PARTIAL_BYTE;
      end
      event_d    = spi_tbs_pkg::EV_DESELECT;
      selected_d = 1'b0;
    end else if (sck_i == last_clock_q) begin
      last_data_d = mosi_i;
    end else begin
      last_clock_d = sck_i;
      if (skip_edge_q) begin
        last_data_d = mosi_i;
        skip_edge_d = 1'b0;
      end else if (sck_i == sample_level) begin
        // Sample edge: shift MOSI in.
        if (mosi_i != last_data_q) begin
          error_d = spi_tbs_pkg::ERR_DATA_MOVED;
        end
        in_shift_d = {in_shift_q[spi_tbs_pkg::ByteW-2:0], mosi_i};
      end else begin
        // Shift edge: advance MISO, and exchange the byte after the eighth bit.
        out_shift_d = {out_shift_q[spi_tbs_pkg::ByteW-2:0], 1'b0};
        bit_count_d = bit_count_q + 3'd1;
        last_data_d = mosi_i;
        if (bit_count_q == spi_tbs_pkg::LastBit) begin
          rx_valid_d  = 1'b1;
          rx_byte_d   = in_shift_q;
          out_shift_d = tx_byte_i;
          tx_taken_d  = 1'b1;
          bit_count_d = '0;
        end
      end
    end
  end

  // State registers, updated on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      selected_q   <= 1'b0;
      last_clock_q <= 1'b0;
      last_data_q  <= 1'b0;
      skip_edge_q  <= 1'b0;
      in_shift_q   <= '0;
      out_shift_q  <= '0;
      bit_count_q  <= '0;
    end else if (in_fire) begin
      selected_q   <= selected_d;
      last_clock_q <= last_clock_d;
      last_data_q  <= last_data_d;
      skip_edge_q  <= skip_edge_d;
      in_shift_q   <= in_shift_d;
      out_shift_q  <= out_shift_d;
      bit_count_q  <= bit_count_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload register.
  logic                          rx_valid_q;
  logic [spi_tbs_pkg::ByteW-1:0] rx_byte_q;
  logic                          tx_taken_q;
  logic [1:0]                    event_q;
  logic [2:0]                    error_q;
  logic                          miso_q;
  logic                          miso_drive_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rx_valid_q   <= rx_valid_d;
      rx_byte_q    <= rx_byte_d;
      tx_taken_q   <= tx_taken_d;
      event_q      <= event_d;
      error_q      <= error_d;
      miso_q       <= selected_d & out_shift_d[spi_tbs_pkg::ByteW-1];
      miso_drive_q <= selected_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rx_valid_o     = rx_valid_q;
  assign rx_byte_o      = rx_byte_q;
  assign tx_taken_o     = tx_taken_q;
  assign select_event_o = event_q;
  assign error_code_o   = error_q;
  assign miso_o         = miso_q;
  assign miso_drive_o   = miso_drive_q;

  // MISO is never high while the pin is not driven.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !miso_drive_o |-> !miso_o)
    else $error("miso high while not driven");

  // A transmit byte is loaded only at select or at a byte exchange.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_taken_o |->
      (select_event_o == spi_tbs_pkg::EV_SELECT) || rx_valid_o)
    else $error("transmit byte taken outside select or exchange");

  // A select event always leaves the block driving MISO.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (select_event_o == spi_tbs_pkg::EV_SELECT) |-> miso_drive_o)
    else $error("selected without MISO drive");

  // A result that is not taken stays in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_byte_o))
    else $error("pending result lost");

endmodule
